@@ rtl/core/lzwp_pkg.sv @@
// Shared constants and types of the LZW variable-width code packer.
package lzwp_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int JUMP_ENTRIES  = 10;

    localparam int CODE_W   = 12;
    localparam int THR_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int WIDTH_W  = 4;
    localparam int START_W  = 4;
    localparam int FILL_W   = 3;
    localparam int BUF_W    = MAX_CODE_BITS + 7;
    localparam int JPOS_W   = 4;
    localparam int JIDX_W   = (JUMP_ENTRIES > 1) ? $clog2(JUMP_ENTRIES) : 1;
    localparam int BYTES_MAX = 3;

    localparam logic [START_W-1:0] START_BITS_RESET = START_W'(9);
    localparam logic [START_W-1:0] START_BITS_MIN   = START_W'(3);
    localparam logic [START_W-1:0] START_BITS_MAX   = START_W'(9);

    localparam logic CMD_PACK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic [BYTES_MAX-1:0][7:0] bytes;
        logic [BYTES_MAX-1:0]      last;
        logic [BYTES_MAX-1:0]      flush;
        logic [1:0]                count;
    } lzwp_burst_t;

endpackage

@@ rtl/core/lzwp_ifs.sv @@
// Handshake interfaces: code items, packed output words and configuration writes.
interface lzwp_item_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [lzwp_pkg::CODE_W-1:0]   code;
    logic                          segment_start;
    logic                          final_code;
    logic [lzwp_pkg::SLOT_W-1:0]   jump_slot;
    logic [lzwp_pkg::THR_W-1:0]    jump_threshold;

    modport source (output valid, cmd, code, segment_start, final_code, jump_slot,
                    jump_threshold, input ready);
    modport sink (input valid, cmd, code, segment_start, final_code, jump_slot,
                  jump_threshold, output ready);
endinterface

interface lzwp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;

    modport source (output valid, out_byte, last_of_run, stream_end, input ready);
    modport sink (input valid, out_byte, last_of_run, stream_end, output ready);
endinterface

interface lzwp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lzwp_pkg::START_W-1:0] start_bits;

    modport source (output valid, start_bits, input ready);
    modport sink (input valid, start_bits, output ready);
endinterface

@@ rtl/core/lzwp_pack_unit.sv @@
// Input register, code width tracking, jump table and bit accumulator.
module lzwp_pack_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    lzwp_item_if.sink            codes,
    lzwp_cfg_if.sink             cfg,
    output logic                 burst_valid,
    input  logic                 burst_ready,
    output lzwp_pkg::lzwp_burst_t burst
);
    import lzwp_pkg::*;

    logic                  item_valid_reg;
    logic                  cmd_reg;
    logic [CODE_W-1:0]     code_reg;
    logic                  seg_reg;
    logic                  fin_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [THR_W-1:0]      thr_reg;

    logic [START_W-1:0]    start_bits_reg;
    logic [BUF_W-1:0]      bit_buffer_reg, bit_buffer_next;
    logic [FILL_W-1:0]     bit_fill_reg, bit_fill_next;
    logic [WIDTH_W-1:0]    code_width_reg, code_width_next;
    logic [JPOS_W-1:0]     jump_pos_reg, jump_pos_next;
    logic [THR_W-1:0]      code_counter_reg, code_counter_next;
    logic [THR_W-1:0]      jump_table [JUMP_ENTRIES];

    logic                  fire;
    logic [START_W-1:0]    eff_start;
    logic [WIDTH_W-1:0]    cw0;
    logic [JPOS_W-1:0]     jp0;
    logic [THR_W-1:0]      cnt0, cnt1;
    logic [CODE_W-1:0]     clear_code;
    logic [THR_W-1:0]      thr_rd;
    logic                  adv;
    logic [CODE_W-1:0]     code_mask;
    logic [BUF_W-1:0]      acc, acc_s;
    logic [4:0]            fill_sum;
    logic [1:0]            nb;
    logic [7:0]            flush_byte;
    logic [1:0]            n_total;

    assign fire        = item_valid_reg && burst_ready;
    assign codes.ready = !item_valid_reg || burst_ready;
    assign burst_valid = item_valid_reg;
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        if (start_bits_reg < START_BITS_MIN)
        begin
            eff_start = START_BITS_MIN;
        end
        else if (start_bits_reg > START_BITS_MAX)
        begin
            eff_start = START_BITS_MAX;
        end
        else
        begin
            eff_start = start_bits_reg;
        end

        cw0  = seg_reg ? WIDTH_W'(eff_start) : code_width_reg;
        jp0  = seg_reg ? '0 : jump_pos_reg;
        cnt0 = seg_reg ? THR_W'(1) : code_counter_reg;

        clear_code = CODE_W'(1) << (eff_start - START_W'(1));
        cnt1 = (code_reg == clear_code) ? '0 : cnt0;

        thr_rd = jump_table[jp0[JIDX_W-1:0]];
        adv = (cw0 < WIDTH_W'(MAX_CODE_BITS)) && (jp0 < JPOS_W'(JUMP_ENTRIES))
              && ({1'b0, cnt1} > ({1'b0, thr_rd} + 17'd1));

        code_width_next = cw0 + WIDTH_W'(adv);
        jump_pos_next   = jp0 + JPOS_W'(adv);

        code_mask = ~({CODE_W{1'b1}} << code_width_next);
        acc = bit_buffer_reg | (BUF_W'(code_reg & code_mask) << bit_fill_reg);
        fill_sum = 5'(bit_fill_reg) + 5'(code_width_next);
        nb = (fill_sum >= 5'd16) ? 2'd2 : ((fill_sum >= 5'd8) ? 2'd1 : 2'd0);
        acc_s = acc >> {nb, 3'b000};
        flush_byte = acc_s[7:0];

        code_counter_next = (cnt1 < {THR_W{1'b1}}) ? cnt1 + THR_W'(1) : cnt1;

        if (fin_reg)
        begin
            bit_buffer_next = acc_s >> 8;
            bit_fill_next   = '0;
        end
        else
        begin
            bit_buffer_next = acc_s;
            bit_fill_next   = fill_sum[FILL_W-1:0];
        end

        n_total = nb + 2'(fin_reg);
        if (cmd_reg == CMD_LOAD)
        begin
            n_total = '0;
        end

        burst.bytes[0] = (nb >= 2'd1) ? acc[7:0] : flush_byte;
        burst.bytes[1] = (nb == 2'd2) ? acc[15:8] : flush_byte;
        burst.bytes[2] = flush_byte;
        burst.flush[0] = fin_reg && (nb == 2'd0);
        burst.flush[1] = fin_reg && (nb == 2'd1);
        burst.flush[2] = fin_reg && (nb == 2'd2);
        burst.last[0]  = (n_total == 2'd1);
        burst.last[1]  = (n_total == 2'd2);
        burst.last[2]  = (n_total == 2'd3);
        burst.count    = n_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            start_bits_reg   <= START_BITS_RESET;
            bit_buffer_reg   <= '0;
            bit_fill_reg     <= '0;
            code_width_reg   <= WIDTH_W'(START_BITS_RESET);
            jump_pos_reg     <= '0;
            code_counter_reg <= THR_W'(1);
        end
        else
        begin
            if (codes.ready)
            begin
                item_valid_reg <= codes.valid;
            end
            if (cfg.valid)
            begin
                start_bits_reg <= cfg.start_bits;
            end
            if (fire && (cmd_reg == CMD_PACK))
            begin
                bit_buffer_reg   <= bit_buffer_next;
                bit_fill_reg     <= bit_fill_next;
                code_width_reg   <= code_width_next;
                jump_pos_reg     <= jump_pos_next;
                code_counter_reg <= code_counter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (codes.ready && codes.valid)
        begin
            cmd_reg  <= codes.cmd;
            code_reg <= codes.code;
            seg_reg  <= codes.segment_start;
            fin_reg  <= codes.final_code;
            slot_reg <= codes.jump_slot;
            thr_reg  <= codes.jump_threshold;
        end
        if (fire && (cmd_reg == CMD_LOAD) && (slot_reg < SLOT_W'(JUMP_ENTRIES)))
        begin
            jump_table[slot_reg[JIDX_W-1:0]] <= thr_reg;
        end
    end

endmodule

@@ rtl/core/lzwp_byte_queue.sv @@
// Result register holding up to three packed words, drained one per cycle while the output is ready.
module lzwp_byte_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  burst_valid,
    output logic                  burst_ready,
    input  lzwp_pkg::lzwp_burst_t burst,
    lzwp_byte_if.source           packed_out
);
    import lzwp_pkg::*;

    logic [BYTES_MAX-1:0][7:0] bytes_reg;
    logic [BYTES_MAX-1:0]      last_reg;
    logic [BYTES_MAX-1:0]      flush_reg;
    logic [1:0]                count_reg;
    logic [1:0]                rd_ptr_reg;
    logic                      take;

    assign packed_out.valid       = (count_reg != 2'd0);
    assign take                   = packed_out.valid && packed_out.ready;
    assign burst_ready            = (count_reg == 2'd0) || ((count_reg == 2'd1) && take);
    assign packed_out.out_byte    = bytes_reg[rd_ptr_reg];
    assign packed_out.last_of_run = last_reg[rd_ptr_reg];
    assign packed_out.stream_end  = flush_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
        end
        else if (burst_valid && burst_ready)
        begin
            count_reg  <= burst.count;
            rd_ptr_reg <= '0;
        end
        else if (take)
        begin
            count_reg  <= count_reg - 2'd1;
            rd_ptr_reg <= rd_ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_valid && burst_ready)
        begin
            bytes_reg <= burst.bytes;
            last_reg  <= burst.last;
            flush_reg <= burst.flush;
        end
    end

endmodule

@@ rtl/core/lzw_variable_width_code_packer.sv @@
// Top level of the GIF-style LZW variable-width code packer.
//
//  channel  dir  payload                                               role
//  codes    in   cmd, code, segment_start, final_code, jump_slot/thr   code or table load
//  packed   out  out_byte, last_of_run, stream_end                     packed words, LSB first
//  cfg      in   start_bits                                            start code width
//
// An item is registered, then processed combinationally into a three-word result register.
// A code item yields 0 to 3 words, which leave one per cycle while the output is ready;
// a table load yields no words.
// The next item is taken in the same cycle as the last word of the previous one leaves.
// Reset clears the accumulator and width state; the jump table holds no reset value.
module lzw_variable_width_code_packer (
    input  logic        clk,
    input  logic        rst_n,
    lzwp_item_if.sink   codes,
    lzwp_byte_if.source packed_out,
    lzwp_cfg_if.sink    cfg
);
    import lzwp_pkg::*;

    logic        burst_valid;
    logic        burst_ready;
    lzwp_burst_t burst;

    lzwp_pack_unit u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .codes       (codes),
        .cfg         (cfg),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    lzwp_byte_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .packed_out  (packed_out)
    );

endmodule
